// File: rtl/core/stft_pkg.sv
// Shared types and constants of the sparse triple transpose block.
// Used by stft_cell and sparse_triple_fast_transpose; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stft_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int MAX_DIM         = 256;

  localparam int DIM_W   = 9;
  localparam int IDX_W   = 8;
  localparam int VALUE_W = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'd1;

  localparam logic [DIM_W-1:0] COLUMN_COUNT_RST = 9'd256;

  typedef struct packed {
    logic [IDX_W-1:0]          in_row;
    logic [IDX_W-1:0]          in_col;
    logic signed [VALUE_W-1:0] in_value;
    logic                      last_entry;
  } stft_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]          out_row;
    logic [IDX_W-1:0]          out_col;
    logic signed [VALUE_W-1:0] out_value;
    logic                      out_last;
  } stft_out_t;

  typedef struct packed {
    logic [IDX_W-1:0]          row;
    logic [IDX_W-1:0]          col;
    logic signed [VALUE_W-1:0] value;
  } stft_entry_t;

  // What one cell shows its neighbors: its entry, and whether that slot
  // sorts after the word being inserted (empty slots always do).
  typedef struct packed {
    logic        vld;
    logic        gt;
    stft_entry_t ent;
  } stft_link_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } stft_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/stft_cell.sv
// One slot of the sorted entry chain: holds one entry and its valid bit.
// Depends on stft_pkg for the entry, link and control types.
`timescale 1ns / 1ps
`default_nettype none

module stft_cell
  import stft_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire stft_ctl_t   ctl,
  input  wire stft_entry_t new_ent,
  input  wire stft_link_t  prev_link,
  input  wire stft_link_t  next_link,
  output stft_link_t       link
);

  logic        vld_r, vld_nxt;
  stft_entry_t ent_r, ent_nxt;
  logic        gt;

  // Slots with a larger column, or empty, move up; equal columns stay ahead.
  assign gt = !vld_r || (ent_r.col > new_ent.col);

  always_comb begin
    vld_nxt = vld_r;
    ent_nxt = ent_r;
    priority if (ctl.shift) begin
      vld_nxt = next_link.vld;
      ent_nxt = next_link.ent;
    end else if (ctl.ins && gt) begin
      if (prev_link.gt) begin
        vld_nxt = prev_link.vld;
        ent_nxt = prev_link.ent;
      end else begin
        vld_nxt = 1'b1;
        ent_nxt = new_ent;
      end
    end else begin
      // hold the slot
      vld_nxt = vld_r;
      ent_nxt = ent_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign link.vld = vld_r;
  assign link.gt  = gt;
  assign link.ent = ent_r;

endmodule

`default_nettype wire

// File: rtl/core/sparse_triple_fast_transpose.sv
// Sparse matrix transpose over a stream of (row, column, value) words.
// Each accepted word is inserted, in the cycle it is taken, into a chain of
// MAX_ENTRIES cells kept sorted by column, later words behind earlier ones of
// the same column; start is taken every cycle while busy is low. Once the
// word marked last_entry is taken, busy rises if any entry is kept; the
// kept entries then leave from the head of the chain, one per cycle on
// out_valid, with row and column swapped and the final one marked out_last.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Words whose column is at or above column_count, and words beyond
// MAX_ENTRIES, are dropped. Writes to row_count are accepted and have no
// effect. cfg_ready is always high.
// Depends on stft_pkg and stft_cell.
`timescale 1ns / 1ps
`default_nettype none

module sparse_triple_fast_transpose
  import stft_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire stft_in_t             in_data,
  output logic                      out_valid,
  output stft_out_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic [DIM_W-1:0] col_count_r, col_count_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    rem_r, rem_nxt;
  logic             emit_r, emit_nxt;
  logic             out_valid_r, out_valid_nxt;
  stft_out_t        out_data_r, out_data_nxt;

  logic             accept;
  logic             keep;
  logic [CW-1:0]    total;
  stft_ctl_t        ctl;
  stft_entry_t      new_ent;
  stft_link_t       links [MAX_ENTRIES];

  assign cfg_ready = 1'b1;
  assign busy      = emit_r;
  assign accept    = start && !emit_r;

  assign keep = (cnt_r < CW'(MAX_ENTRIES))
             && ({1'b0, in_data.in_col} < col_count_r)
             && ({1'b0, in_data.in_col} < DIM_W'(MAX_DIM));

  assign total = cnt_r + CW'(accept && keep);

  assign new_ent.row   = in_data.in_row;
  assign new_ent.col   = in_data.in_col;
  assign new_ent.value = in_data.in_value;

  assign ctl.ins   = accept && keep;
  assign ctl.shift = emit_r;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    stft_link_t prev_link;
    stft_link_t next_link;

    if (i == 0) begin : g_head
      assign prev_link = '0;
    end else begin : g_body
      assign prev_link = links[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign next_link = '0;
    end else begin : g_inner
      assign next_link = links[i+1];
    end

    stft_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .new_ent   (new_ent),
      .prev_link (prev_link),
      .next_link (next_link),
      .link      (links[i])
    );
  end

  always_comb begin
    col_count_nxt = col_count_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ROW_COUNT:    col_count_nxt = col_count_r;
        CFG_COLUMN_COUNT: col_count_nxt = cfg_data;
        default:          col_count_nxt = col_count_r;
      endcase
    end
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    emit_nxt      = emit_r;
    out_valid_nxt = 1'b0;

    out_data_nxt.out_row   = links[0].ent.col;
    out_data_nxt.out_col   = links[0].ent.row;
    out_data_nxt.out_value = links[0].ent.value;
    out_data_nxt.out_last  = (rem_r == CW'(1));

    if (emit_r) begin
      // drain the head cell; the chain shifts toward it
      out_valid_nxt = 1'b1;
      rem_nxt       = rem_r - CW'(1);
      if (rem_r == CW'(1)) begin
        emit_nxt = 1'b0;
      end
    end else if (accept) begin
      cnt_nxt = total;
      if (in_data.last_entry) begin
        cnt_nxt  = '0;
        rem_nxt  = total;
        emit_nxt = (total != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= COLUMN_COUNT_RST;
      cnt_r       <= '0;
      rem_r       <= '0;
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col_count_r <= col_count_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
